// ===== hw/rtl/event_slot_dispatcher_defines.svh =====
// Assertion macros used by the event slot dispatcher datapath.
`ifndef EVENT_SLOT_DISPATCHER_DEFINES_SVH
`define EVENT_SLOT_DISPATCHER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ESD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("event slot dispatcher assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("event slot dispatcher assertion failed");

`endif

// ===== hw/rtl/esd_pkg.sv =====
// Shared constants, codes and command type of the event slot dispatcher.
package esd_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 3;
   localparam int HANDLE_W      = 5;
   localparam int SLOT_ID_W     = 8;
   localparam int WORD_W        = 16;
   localparam int MASK_W        = 32;

   localparam logic [ACTION_W-1:0] ACT_REGISTER    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_NOTIFY_DATA = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_NOTIFY      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DISPATCH    = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NO_FREE = 3'd1;
   localparam logic [STATUS_W-1:0] STS_IDLE    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NULL    = 3'd3;
   localparam logic [STATUS_W-1:0] STS_BAD     = 3'd4;

   localparam logic [SLOT_ID_W-1:0] NULL_HANDLE = 8'd255;

   typedef struct packed {
      logic capture;
      logic execute;
   } esd_cmd_type;

endpackage

// ===== hw/rtl/esd_datapath.sv =====
// Datapath of the event slot dispatcher: slot tables, pending bits and result register.
`include "event_slot_dispatcher_defines.svh"

module esd_datapath #(
   parameter int SLOTS = esd_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  esd_pkg::esd_cmd_type           cmd,
   input  logic [esd_pkg::ACTION_W-1:0]   req_action,
   input  logic                           req_low_priority,
   input  logic [esd_pkg::WORD_W-1:0]     req_entry_address,
   input  logic [esd_pkg::SLOT_ID_W-1:0]  req_slot_handle,
   input  logic [esd_pkg::WORD_W-1:0]     req_payload,
   input  logic [esd_pkg::MASK_W-1:0]     req_clear_mask,
   output logic [esd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [esd_pkg::HANDLE_W-1:0]   rsp_handle_out,
   output logic [esd_pkg::WORD_W-1:0]     rsp_entry_out,
   output logic [esd_pkg::WORD_W-1:0]     rsp_data_out
);
   import esd_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [ACTION_W-1:0]  action_ff;
   logic                 low_ff;
   logic [WORD_W-1:0]    entry_addr_ff;
   logic [SLOT_ID_W-1:0] handle_ff;
   logic [WORD_W-1:0]    payload_ff;
   logic [MASK_W-1:0]    mask_ff;

   logic [SLOTS-1:0]     slot_used_ff, slot_used_in;
   logic [SLOTS-1:0]     pending_ff, pending_in;
   logic [SLOTS-1:0]     arg_valid_ff, arg_valid_in;
   logic [WORD_W-1:0]    entry_tab_ff [SLOTS];
   logic [WORD_W-1:0]    arg_tab_ff [SLOTS];

   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [HANDLE_W-1:0]  handle_out_ff, handle_out_in;
   logic [WORD_W-1:0]    entry_out_ff, entry_out_in;
   logic [WORD_W-1:0]    data_out_ff, data_out_in;

   logic                 up_found, dn_found, alloc_found;
   logic [SLOT_W-1:0]    up_idx, dn_idx, alloc_idx, pick_idx, notify_idx;
   logic                 wr_entry, wr_arg;

   always_comb begin
      up_found = 1'b0;
      up_idx   = '0;
      dn_found = 1'b0;
      dn_idx   = '0;
      pick_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            up_found = 1'b1;
            up_idx   = SLOT_W'(i);
         end
         if (pending_ff[i]) begin
            pick_idx = SLOT_W'(i);
         end
      end
      // The downward search stops above slot zero.
      for (int i = 1; i < SLOTS; i++) begin
         if (!slot_used_ff[i]) begin
            dn_found = 1'b1;
            dn_idx   = SLOT_W'(i);
         end
      end
   end

   assign alloc_found = low_ff ? dn_found : up_found;
   assign alloc_idx   = low_ff ? dn_idx : up_idx;
   assign notify_idx  = handle_ff[SLOT_W-1:0];

   always_comb begin
      slot_used_in  = slot_used_ff;
      pending_in    = pending_ff;
      arg_valid_in  = arg_valid_ff;
      status_in     = STS_OK;
      handle_out_in = '0;
      entry_out_in  = '0;
      data_out_in   = '0;
      wr_entry      = 1'b0;
      wr_arg        = 1'b0;
      case (action_ff)
         ACT_REGISTER: begin
            if (alloc_found) begin
               slot_used_in[alloc_idx] = 1'b1;
               wr_entry                = 1'b1;
               handle_out_in           = HANDLE_W'(alloc_idx);
            end else begin
               status_in = STS_NO_FREE;
            end
         end
         ACT_NOTIFY_DATA, ACT_NOTIFY: begin
            if (handle_ff == NULL_HANDLE) begin
               status_in = STS_NULL;
            end else if (handle_ff >= SLOT_ID_W'(SLOTS)) begin
               status_in = STS_BAD;
            end else begin
               pending_in[notify_idx] = 1'b1;
               if (action_ff == ACT_NOTIFY_DATA) begin
                  wr_arg                   = 1'b1;
                  arg_valid_in[notify_idx] = 1'b1;
               end
            end
         end
         ACT_CLEAR: begin
            pending_in = pending_ff & ~mask_ff[SLOTS-1:0];
         end
         ACT_DISPATCH: begin
            if (pending_ff == '0) begin
               status_in = STS_IDLE;
            end else begin
               pending_in[pick_idx] = 1'b0;
               handle_out_in        = HANDLE_W'(pick_idx);
               entry_out_in = slot_used_ff[pick_idx] ? entry_tab_ff[pick_idx] : '0;
               data_out_in  = arg_valid_ff[pick_idx] ? arg_tab_ff[pick_idx] : '0;
            end
         end
         default: begin
            status_in = STS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
         pending_ff   <= '0;
         arg_valid_ff <= '0;
      end else if (cmd.execute) begin
         slot_used_ff <= slot_used_in;
         pending_ff   <= pending_in;
         arg_valid_ff <= arg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff     <= req_action;
         low_ff        <= req_low_priority;
         entry_addr_ff <= req_entry_address;
         handle_ff     <= req_slot_handle;
         payload_ff    <= req_payload;
         mask_ff       <= req_clear_mask;
      end
      if (cmd.execute) begin
         status_ff     <= status_in;
         handle_out_ff <= handle_out_in;
         entry_out_ff  <= entry_out_in;
         data_out_ff   <= data_out_in;
         if (wr_entry) begin
            entry_tab_ff[alloc_idx] <= entry_addr_ff;
         end
         if (wr_arg) begin
            arg_tab_ff[notify_idx] <= payload_ff;
         end
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_handle_out = handle_out_ff;
   assign rsp_entry_out  = entry_out_ff;
   assign rsp_data_out   = data_out_ff;

   `ESD_ASSERT_NEXT(a_state_held_when_quiet, clock, reset, !reset && !cmd.execute, $stable(slot_used_ff) && $stable(pending_ff))
   `ESD_ASSERT_NEXT(a_empty_dispatch_idle, clock, reset, cmd.execute && action_ff == ACT_DISPATCH && pending_ff == '0, status_ff == STS_IDLE)
   `ESD_ASSERT_NOW(a_dispatch_pick_pending, clock, reset, cmd.execute && action_ff == ACT_DISPATCH && pending_ff != '0, pending_ff[pick_idx] && !pending_in[pick_idx])

endmodule

// ===== hw/rtl/esd_controller.sv =====
// Controller of the event slot dispatcher: sequences capture, execution and result handshake.
module esd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esd_pkg::esd_cmd_type cmd
);
   import esd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.execute  = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.execute) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/event_slot_dispatcher.sv =====
// Top level of the event slot dispatcher.
// The block keeps a table of event handler slots, each with a pending bit.
// Every request transaction carries one action (register, notify with data,
// notify only, clear mask, dispatch) and yields exactly one response
// transaction with status, handle, entry address and data word.
// A request is taken when req_valid is high and req_stall is low; a response
// is taken when rsp_valid is high and rsp_stall is low.
// The request is captured in the idle state and executed in the execute state,
// which loads the result registers and raises rsp_valid. Each request occupies
// the slot search and update logic until it has executed, and req_stall stays
// high till then. The next request can be taken while the previous response
// still waits. When the receiver stalls, the response is held and the block
// finishes no further request until the response has been taken.
// Reset clears all slot allocations, pending bits and data-valid flags at
// once; the block is ready for a request as soon as reset is released.
module event_slot_dispatcher #(
   parameter int SLOTS = esd_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [esd_pkg::ACTION_W-1:0]   req_action,
   input  logic                           req_low_priority,
   input  logic [esd_pkg::WORD_W-1:0]     req_entry_address,
   input  logic [esd_pkg::SLOT_ID_W-1:0]  req_slot_handle,
   input  logic [esd_pkg::WORD_W-1:0]     req_payload,
   input  logic [esd_pkg::MASK_W-1:0]     req_clear_mask,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [esd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [esd_pkg::HANDLE_W-1:0]   rsp_handle_out,
   output logic [esd_pkg::WORD_W-1:0]     rsp_entry_out,
   output logic [esd_pkg::WORD_W-1:0]     rsp_data_out
);
   import esd_pkg::*;

   esd_cmd_type cmd;

   esd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   esd_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_action        (req_action),
      .req_low_priority  (req_low_priority),
      .req_entry_address (req_entry_address),
      .req_slot_handle   (req_slot_handle),
      .req_payload       (req_payload),
      .req_clear_mask    (req_clear_mask),
      .rsp_status        (rsp_status),
      .rsp_handle_out    (rsp_handle_out),
      .rsp_entry_out     (rsp_entry_out),
      .rsp_data_out      (rsp_data_out)
   );

endmodule

// ===== tb/slot_dispatch_checker.sv =====
// Checker that predicts and compares the response transactions of the event slot dispatcher.
module slot_dispatch_checker #(
   parameter int SLOTS = esd_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [esd_pkg::ACTION_W-1:0]   req_action,
   input  logic                           req_low_priority,
   input  logic [esd_pkg::WORD_W-1:0]     req_entry_address,
   input  logic [esd_pkg::SLOT_ID_W-1:0]  req_slot_handle,
   input  logic [esd_pkg::WORD_W-1:0]     req_payload,
   input  logic [esd_pkg::MASK_W-1:0]     req_clear_mask,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [esd_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [esd_pkg::HANDLE_W-1:0]   rsp_handle_out,
   input  logic [esd_pkg::WORD_W-1:0]     rsp_entry_out,
   input  logic [esd_pkg::WORD_W-1:0]     rsp_data_out,
   output int                             error_count,
   output int                             outstanding,
   output int                             compared_count,
   output int                             table_full_count
);
   import esd_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [WORD_W-1:0]   entry;
      logic [WORD_W-1:0]   data;
   } slot_outcome_type;

   localparam logic [MASK_W-1:0] SLOT_MASK = {MASK_W{1'b1}} >> (MASK_W - SLOTS);

   logic [MASK_W-1:0] slot_used;
   logic [MASK_W-1:0] pending_bits;
   logic [WORD_W-1:0] entry_table [SLOTS];
   logic [WORD_W-1:0] arg_table [SLOTS];
   slot_outcome_type  awaited_outcomes [$];
   slot_outcome_type  oldest;
   int                mismatches = 0;
   int                compared = 0;
   int                table_full = 0;

   initial begin
      error_count      = 0;
      outstanding      = 0;
      compared_count   = 0;
      table_full_count = 0;
   end

   function automatic slot_outcome_type apply_action(
      input logic [ACTION_W-1:0]  action,
      input logic                 low_priority,
      input logic [WORD_W-1:0]    entry_address,
      input logic [SLOT_ID_W-1:0] slot_handle,
      input logic [WORD_W-1:0]    payload,
      input logic [MASK_W-1:0]    clear_mask
   );
      slot_outcome_type res;
      int found;
      res = '0;
      res.status = STS_OK;
      found = -1;
      case (action)
         ACT_REGISTER: begin
            if (!low_priority) begin
               for (int i = 0; i < SLOTS; i++)
                  if (found < 0 && !slot_used[i]) found = i;
            end else begin
               for (int i = SLOTS - 1; i > 0; i--)
                  if (found < 0 && !slot_used[i]) found = i;
            end
            if (found < 0) begin
               res.status = STS_NO_FREE;
            end else begin
               slot_used[found]   = 1'b1;
               entry_table[found] = entry_address;
               res.handle         = found[HANDLE_W-1:0];
            end
         end
         ACT_NOTIFY_DATA, ACT_NOTIFY: begin
            if (slot_handle == NULL_HANDLE) begin
               res.status = STS_NULL;
            end else if (slot_handle >= SLOTS) begin
               res.status = STS_BAD;
            end else begin
               if (action == ACT_NOTIFY_DATA) arg_table[slot_handle] = payload;
               pending_bits[slot_handle] = 1'b1;
            end
         end
         ACT_CLEAR: begin
            pending_bits = pending_bits & ~(clear_mask & SLOT_MASK);
         end
         ACT_DISPATCH: begin
            for (int i = 0; i < SLOTS; i++)
               if (found < 0 && pending_bits[i]) found = i;
            if (found < 0) begin
               res.status = STS_IDLE;
            end else begin
               pending_bits[found] = 1'b0;
               res.handle = found[HANDLE_W-1:0];
               res.entry  = entry_table[found];
               res.data   = arg_table[found];
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [WORD_W-1:0] expected,
                                         input logic [WORD_W-1:0] actual);
      if (expected !== actual) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         slot_used    = '0;
         pending_bits = '0;
         for (int i = 0; i < SLOTS; i++) begin
            entry_table[i] = '0;
            arg_table[i]   = '0;
         end
         awaited_outcomes.delete();
      end else begin
         if (req_valid && !req_stall)
            awaited_outcomes.push_back(apply_action(req_action, req_low_priority,
               req_entry_address, req_slot_handle, req_payload, req_clear_mask));
         if (rsp_valid && !rsp_stall) begin
            compared++;
            if (awaited_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, got status %0d handle %0d",
                        $time, rsp_status, rsp_handle_out);
            end else begin
               oldest = awaited_outcomes.pop_front();
               compare_field("status", WORD_W'(oldest.status), WORD_W'(rsp_status));
               compare_field("handle_out", WORD_W'(oldest.handle), WORD_W'(rsp_handle_out));
               compare_field("entry_out", oldest.entry, rsp_entry_out);
               compare_field("data_out", oldest.data, rsp_data_out);
               if (oldest.status == STS_NO_FREE) table_full++;
            end
         end
      end
      error_count      <= mismatches;
      outstanding      <= awaited_outcomes.size();
      compared_count   <= compared;
      table_full_count <= table_full;
   end

endmodule

// ===== tb/tb_event_slot_dispatcher.sv =====
// Testbench top that drives requests, stalls responses and reports the verdict.
module tb_event_slot_dispatcher;
   import esd_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int RANDOM_ITEMS = 1550;
   localparam int EARLY_ITEMS  = 250;
   localparam int QUIET_FIRST  = 700;
   localparam int QUIET_LAST   = 1000;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [ACTION_W-1:0] ACT_UNDEF_FIRST = ACT_DISPATCH + 1'b1;
   localparam logic [ACTION_W-1:0] ACT_UNDEF_LAST  = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [ACTION_W-1:0]  req_action;
   logic                 req_low_priority;
   logic [WORD_W-1:0]    req_entry_address;
   logic [SLOT_ID_W-1:0] req_slot_handle;
   logic [WORD_W-1:0]    req_payload;
   logic [MASK_W-1:0]    req_clear_mask;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [HANDLE_W-1:0]  rsp_handle_out;
   logic [WORD_W-1:0]    rsp_entry_out;
   logic [WORD_W-1:0]    rsp_data_out;
   int                   error_count;
   int                   outstanding;
   int                   compared_count;
   int                   table_full_count;
   int                   sent_count = 0;
   int                   cycle_count = 0;

   event_slot_dispatcher #(.SLOTS(SLOTS)) u_top (.*);

   slot_dispatch_checker #(.SLOTS(SLOTS)) u_dispatch_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("event_slot_dispatcher verification failed");
         $finish;
      end
   end

   task automatic offer(input logic [ACTION_W-1:0] action, input logic low_priority,
                        input logic [WORD_W-1:0] entry_address,
                        input logic [SLOT_ID_W-1:0] slot_handle,
                        input logic [WORD_W-1:0] payload, input logic [MASK_W-1:0] clear_mask);
      req_valid         <= 1'b1;
      req_action        <= action;
      req_low_priority  <= low_priority;
      req_entry_address <= entry_address;
      req_slot_handle   <= slot_handle;
      req_payload       <= payload;
      req_clear_mask    <= clear_mask;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if ((sent_count < QUIET_FIRST || sent_count > QUIET_LAST) && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (sent_count >= QUIET_FIRST && sent_count <= QUIET_LAST) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 12);
         end
      end
   end

   initial begin
      logic [ACTION_W-1:0]  act;
      logic                 low;
      logic [SLOT_ID_W-1:0] handle;
      logic [MASK_W-1:0]    mask;
      int                   roll;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= ACT_REGISTER;
      req_low_priority  <= 1'b0;
      req_entry_address <= '0;
      req_slot_handle   <= '0;
      req_payload       <= '0;
      req_clear_mask    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, unregistered slots, bad handles, both search directions.
      offer(ACT_DISPATCH,    1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_CLEAR,       1'b0, 16'h0000, 8'd0,        16'h0000, '1);
      offer(ACT_NOTIFY_DATA, 1'b0, 16'h0000, 8'd5,        16'hFFFF, '0);
      offer(ACT_NOTIFY,      1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_DISPATCH,    1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_DISPATCH,    1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_DISPATCH,    1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_NOTIFY,      1'b0, 16'h0000, NULL_HANDLE, 16'h0000, '0);
      offer(ACT_NOTIFY_DATA, 1'b0, 16'h0000, 8'(SLOTS),   16'h5A5A, '0);
      offer(ACT_NOTIFY,      1'b0, 16'h0000, 8'd254,      16'h0000, '0);
      offer(ACT_REGISTER,    1'b0, 16'hFFFF, 8'd0,        16'h0000, '0);
      offer(ACT_REGISTER,    1'b1, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_REGISTER,    1'b1, 16'hA5A5, 8'd0,        16'h0000, '0);
      offer(ACT_NOTIFY_DATA, 1'b0, 16'h0000, 8'(SLOTS-1), 16'h0000, '0);
      offer(ACT_NOTIFY_DATA, 1'b0, 16'h0000, 8'd0,        16'h1234, '0);
      offer(ACT_NOTIFY,      1'b0, 16'h0000, 8'(SLOTS-2), 16'h0000, '0);
      offer(ACT_CLEAR,       1'b0, 16'h0000, 8'd0,        16'h0000, 32'h4000_0000);
      offer(ACT_DISPATCH,    1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_DISPATCH,    1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_DISPATCH,    1'b0, 16'h0000, 8'd0,        16'h0000, '0);
      offer(ACT_UNDEF_FIRST,        1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, '1);
      offer(ACT_UNDEF_FIRST + 1'b1, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, '1);
      offer(ACT_UNDEF_LAST,         1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, '1);
      offer(ACT_CLEAR,       1'b0, 16'h0000, 8'd0,        16'h0000, '0);

      // Early on only downward searches, so the table fills while slot 0 is still free.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (n < EARLY_ITEMS) begin
            if (roll < 30)      act = ACT_REGISTER;
            else if (roll < 50) act = ACT_NOTIFY_DATA;
            else if (roll < 62) act = ACT_NOTIFY;
            else if (roll < 70) act = ACT_CLEAR;
            else if (roll < 96) act = ACT_DISPATCH;
            else act = ACTION_W'($urandom_range(ACT_UNDEF_LAST, ACT_UNDEF_FIRST));
            low = 1'b1;
         end else begin
            if (roll < 8)       act = ACT_REGISTER;
            else if (roll < 38) act = ACT_NOTIFY_DATA;
            else if (roll < 55) act = ACT_NOTIFY;
            else if (roll < 63) act = ACT_CLEAR;
            else if (roll < 95) act = ACT_DISPATCH;
            else act = ACTION_W'($urandom_range(ACT_UNDEF_LAST, ACT_UNDEF_FIRST));
            low = 1'($urandom_range(1));
         end
         roll = $urandom_range(99);
         if (roll < 84)      handle = SLOT_ID_W'($urandom_range(SLOTS - 1));
         else if (roll < 92) handle = SLOT_ID_W'($urandom_range(NULL_HANDLE - 1, SLOTS));
         else if (roll < 97) handle = NULL_HANDLE;
         else                handle = SLOT_ID_W'($urandom_range(NULL_HANDLE));
         roll = $urandom_range(99);
         if (roll < 40)      mask = $urandom;
         else if (roll < 60) mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
         else if (roll < 70) mask = '1;
         else                mask = $urandom & $urandom;
         offer(act, low, WORD_W'($urandom_range(16'hFFFF)), handle,
               WORD_W'($urandom_range(16'hFFFF)), mask);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d request transactions: every action, undefined codes, null and",
               sent_count);
      $display("out-of-range handles; %0d responses compared, %0d full-table refusals.",
               compared_count, table_full_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("event_slot_dispatcher verification clean");
      end else begin
         $display("event_slot_dispatcher verification failed");
      end
      $finish;
   end

endmodule
